### rtl/core/avihp_pkg.sv
// Types, constants, control program and magic table of the AVI header parser.
`default_nettype none

package avihp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } avihp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] codec;
    logic [19:0] frame_rate;
    logic [41:0] duration_ms;
    logic [31:0] frame_width;
    logic [31:0] frame_height;
    logic        rate_valid;
  } avihp_out_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAIN  = 3'd1;
  localparam logic [2:0] ST_BAD_STRM  = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_BACK_SEEK = 3'd4;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SKIP,
    OP_MAGIC,
    OP_CAP_BLEN,
    OP_CAP_USEC,
    OP_CAP_FRAMES,
    OP_CAP_W,
    OP_CAP_H,
    OP_CAP_CODEC
  } op_e;

  typedef enum logic [1:0] {
    FIN_STAY,
    FIN_NEXT,
    FIN_HDR_CHECK,
    FIN_EMIT
  } fin_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] reps;
    fin_e       fin;
  } ctrl_t;

  localparam int StepW = 5;
  localparam logic [StepW-1:0] STEP_FIRST = 5'd0;
  localparam logic [StepW-1:0] STEP_SEEK  = 5'd12;
  localparam logic [StepW-1:0] STEP_STRM  = 5'd13;
  localparam logic [StepW-1:0] STEP_DONE  = 5'd20;

  localparam int MagicLen = 36;
  localparam int MagicW   = 6;
  localparam logic [8*MagicLen-1:0] MAGIC_STR = "RIFFAVI LISThdrlavihLISTstrlstrhvids";

  localparam logic [31:0] MIN_BLOCK_LEN = 32'd40;

  localparam int FpsW     = 20;
  localparam int DurW     = 42;
  localparam int DivW     = 43;
  localparam int DivisorW = 33;
  localparam int DivCntW  = 6;
  localparam logic [DivW-1:0] FPS_NUM   = 43'd2000000;
  localparam logic [DivW-1:0] DUR_SCALE = 43'd2000;

  typedef enum logic [2:0] {
    M_IDLE,
    M_FPS,
    M_MUL,
    M_DSTART,
    M_DUR
  } math_e;

  typedef struct packed {
    logic        emit;
    logic [2:0]  status;
    logic [31:0] usec;
    logic [31:0] frames;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] codec;
  } avihp_seq_t;

  function automatic ctrl_t ctrl_rom(input logic [StepW-1:0] step);
    ctrl_t w;
    case (step)
      5'd0:    w = '{OP_MAGIC,      4'd3,  FIN_NEXT};
      5'd1:    w = '{OP_SKIP,       4'd3,  FIN_NEXT};
      5'd2:    w = '{OP_MAGIC,      4'd7,  FIN_NEXT};
      5'd3:    w = '{OP_SKIP,       4'd3,  FIN_NEXT};
      5'd4:    w = '{OP_MAGIC,      4'd7,  FIN_NEXT};
      5'd5:    w = '{OP_CAP_BLEN,   4'd3,  FIN_NEXT};
      5'd6:    w = '{OP_CAP_USEC,   4'd3,  FIN_NEXT};
      5'd7:    w = '{OP_SKIP,       4'd11, FIN_NEXT};
      5'd8:    w = '{OP_CAP_FRAMES, 4'd3,  FIN_NEXT};
      5'd9:    w = '{OP_SKIP,       4'd11, FIN_NEXT};
      5'd10:   w = '{OP_CAP_W,      4'd3,  FIN_NEXT};
      5'd11:   w = '{OP_CAP_H,      4'd3,  FIN_HDR_CHECK};
      5'd12:   w = '{OP_SKIP,       4'd0,  FIN_NEXT};
      5'd13:   w = '{OP_MAGIC,      4'd3,  FIN_NEXT};
      5'd14:   w = '{OP_SKIP,       4'd3,  FIN_NEXT};
      5'd15:   w = '{OP_MAGIC,      4'd7,  FIN_NEXT};
      5'd16:   w = '{OP_SKIP,       4'd3,  FIN_NEXT};
      5'd17:   w = '{OP_MAGIC,      4'd3,  FIN_NEXT};
      5'd18:   w = '{OP_CAP_CODEC,  4'd3,  FIN_NEXT};
      5'd19:   w = '{OP_SKIP,       4'd3,  FIN_EMIT};
      default: w = '{OP_IDLE,       4'd0,  FIN_STAY};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [MagicW-1:0] idx);
    int k;
    k = MagicLen - 1 - int'(idx);
    if (k < 0) begin
      k = 0;
    end
    return MAGIC_STR[8*k +: 8];
  endfunction

endpackage

`default_nettype wire

### rtl/core/avi_header_parser_top.sv
// Top level of the AVI header parser: handshakes, rate math and result register.
//
// The input channel takes one file byte per beat, in file order; end_of_file
// marks the last byte of a file, after which the parser starts over on the
// next beat. A control program in a small table walks the header one step
// per field, one byte per cycle while the input is not held off, checks the
// magic, captures the header words and seeks forward to the stream header.
// The output channel carries at most one result beat per file. Error results
// and the short-file result appear in the result register in the cycle after
// the deciding byte. A good header with a nonzero frame time starts the frame
// rate division on the one shared restoring divider, then a multiply and the
// duration division; the result is registered when that division is done, and
// the input is held off until then. A zero frame rate gives a result without
// the rates. Bytes are taken every cycle otherwise; the output register lets
// the input run on while a result waits, except for a byte that would produce
// another result. Reset clears the program counter and the result valid flag.
`default_nettype none

module avi_header_parser_top (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire avihp_pkg::avihp_in_t   in_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  output avihp_pkg::avihp_out_t       out_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i
);
  import avihp_pkg::*;

  math_e               math_q, math_d;
  logic [FpsW-1:0]     fps_q, fps_d;
  logic [DivW-1:0]     prod_q, prod_d;
  avihp_out_t          out_q, out_d;
  logic                out_valid_q, out_valid_d;

  avihp_seq_t          seq;
  logic                in_ready;
  logic                in_fire;
  logic                div_start;
  logic [DivW-1:0]     div_dividend;
  logic [DivisorW-1:0] div_divisor;
  logic                div_busy;
  logic                div_done;
  logic [DivW-1:0]     div_quot;

  avihp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (in_fire),
    .in_i   (in_i),
    .seq_o  (seq)
  );

  avihp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    in_ready     = (math_q == M_IDLE) && (!seq.emit || !out_valid_q || out_ready_i);
    in_fire      = in_valid_i && in_ready;
    math_d       = math_q;
    fps_d        = fps_q;
    prod_d       = prod_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    div_start    = 1'b0;
    div_dividend = prod_q;
    div_divisor  = {{(DivisorW-FpsW-1){1'b0}}, fps_q, 1'b0};

    case (math_q)
      M_IDLE: begin
        if (in_fire && seq.emit) begin
          if ((seq.status == ST_OK) && (seq.usec != '0)) begin
            div_start    = 1'b1;
            div_dividend = FPS_NUM + DivW'(seq.usec);
            div_divisor  = {seq.usec, 1'b0};
            math_d       = M_FPS;
          end else begin
            out_valid_d = 1'b1;
            out_d       = '0;
            out_d.status = seq.status;
            if (seq.status == ST_OK) begin
              out_d.codec        = seq.codec;
              out_d.frame_width  = seq.width;
              out_d.frame_height = seq.height;
            end
          end
        end
      end
      M_FPS: begin
        if (div_done) begin
          if (div_quot == '0) begin
            out_valid_d        = 1'b1;
            out_d              = '0;
            out_d.status       = ST_OK;
            out_d.codec        = seq.codec;
            out_d.frame_width  = seq.width;
            out_d.frame_height = seq.height;
            math_d             = M_IDLE;
          end else begin
            fps_d  = div_quot[FpsW-1:0];
            math_d = M_MUL;
          end
        end
      end
      M_MUL: begin
        prod_d = DivW'(seq.frames) * DUR_SCALE + DivW'(fps_q);
        math_d = M_DSTART;
      end
      M_DSTART: begin
        div_start = 1'b1;
        math_d    = M_DUR;
      end
      M_DUR: begin
        if (div_done) begin
          out_valid_d        = 1'b1;
          out_d.status       = ST_OK;
          out_d.codec        = seq.codec;
          out_d.frame_rate   = fps_q;
          out_d.duration_ms  = div_quot[DurW-1:0];
          out_d.frame_width  = seq.width;
          out_d.frame_height = seq.height;
          out_d.rate_valid   = 1'b1;
          math_d             = M_IDLE;
        end
      end
      default: math_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      math_q      <= M_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      math_q      <= math_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fps_q  <= fps_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = in_ready;
  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  a_hold_input_during_math: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (math_q != M_IDLE) |-> !in_ready_o) else $error("input taken while dividing");

  a_done_in_wait_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((math_q == M_FPS) || (math_q == M_DUR))) else $error("stray divider done");

  a_divider_idle_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (math_q == M_IDLE) |-> !div_busy) else $error("divider running with no math pending");

endmodule

`default_nettype wire

### rtl/core/avihp_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module avihp_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [avihp_pkg::DivW-1:0]     dividend_i,
  input  wire logic [avihp_pkg::DivisorW-1:0] divisor_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [avihp_pkg::DivW-1:0]          quot_o
);
  import avihp_pkg::*;

  logic                run_q, run_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [DivW-1:0]     quo_q, quo_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] dvs_q, dvs_d;
  logic [DivisorW:0]   trial;
  logic [DivisorW:0]   diff;
  logic                fits;

  always_comb begin
    trial  = {rem_q, quo_q[DivW-1]};
    diff   = trial - {1'b0, dvs_q};
    fits   = (trial >= {1'b0, dvs_q});
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = DivCntW'(DivW - 1);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      quo_d = {quo_q[DivW-2:0], fits};
      rem_d = fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (rem_q < dvs_q)) else $error("partial remainder not below divisor");

  a_nonzero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (divisor_i != '0)) else $error("division started with zero divisor");

  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q) else $error("done raised while still running");

endmodule

`default_nettype wire

### rtl/core/avihp_seq.sv
// Microcoded byte sequencer that checks magic and captures header words.
`default_nettype none

module avihp_seq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  beat_i,
  input  wire avihp_pkg::avihp_in_t  in_i,
  output avihp_pkg::avihp_seq_t      seq_o
);
  import avihp_pkg::*;

  logic [StepW-1:0]  step_q, step_d;
  logic [31:0]       rep_q, rep_d;
  logic              bad_q, bad_d;
  logic [MagicW-1:0] mag_q, mag_d;
  logic [31:0]       blen_q, blen_d;
  logic [31:0]       usec_q, usec_d;
  logic [31:0]       frames_q, frames_d;
  logic [31:0]       width_q, width_d;
  logic [31:0]       height_q, height_d;
  logic [31:0]       codec_q, codec_d;

  ctrl_t ctl;
  ctrl_t nxt_ctl;
  ctrl_t strm_ctl;
  ctrl_t first_ctl;
  logic  last;
  logic  done;
  logic  hdr_err;
  logic  strm_hit;
  logic  emit;
  logic [2:0] status;

  always_comb begin
    ctl       = ctrl_rom(step_q);
    nxt_ctl   = ctrl_rom(StepW'(step_q + 1'b1));
    strm_ctl  = ctrl_rom(STEP_STRM);
    first_ctl = ctrl_rom(STEP_FIRST);
    last      = (rep_q == '0);
    done      = (ctl.op == OP_IDLE);
    hdr_err   = (ctl.fin == FIN_HDR_CHECK) && last && (bad_q || (blen_q < MIN_BLOCK_LEN));
    strm_hit  = (ctl.fin == FIN_EMIT) && last;
    emit      = hdr_err || strm_hit || (in_i.end_of_file && !done);
    if (hdr_err) begin
      status = bad_q ? ST_BAD_MAIN : ST_BACK_SEEK;
    end else if (strm_hit) begin
      status = bad_q ? ST_BAD_STRM : ST_OK;
    end else begin
      status = ST_SHORT;
    end

    step_d   = step_q;
    rep_d    = rep_q;
    bad_d    = bad_q;
    mag_d    = mag_q;
    blen_d   = blen_q;
    usec_d   = usec_q;
    frames_d = frames_q;
    width_d  = width_q;
    height_d = height_q;
    codec_d  = codec_q;

    if (beat_i) begin
      case (ctl.op)
        OP_MAGIC: begin
          mag_d = mag_q + 1'b1;
          if (in_i.data_byte != magic_byte(mag_q)) begin
            bad_d = 1'b1;
          end
        end
        OP_CAP_BLEN:   blen_d   = {in_i.data_byte, blen_q[31:8]};
        OP_CAP_USEC:   usec_d   = {in_i.data_byte, usec_q[31:8]};
        OP_CAP_FRAMES: frames_d = {in_i.data_byte, frames_q[31:8]};
        OP_CAP_W:      width_d  = {in_i.data_byte, width_q[31:8]};
        OP_CAP_H:      height_d = {in_i.data_byte, height_q[31:8]};
        OP_CAP_CODEC:  codec_d  = {in_i.data_byte, codec_q[31:8]};
        default: ;
      endcase

      if (!done) begin
        if (last) begin
          case (ctl.fin)
            FIN_NEXT: begin
              step_d = StepW'(step_q + 1'b1);
              rep_d  = {28'd0, nxt_ctl.reps};
            end
            FIN_HDR_CHECK: begin
              if (hdr_err) begin
                step_d = STEP_DONE;
              end else if (blen_q == MIN_BLOCK_LEN) begin
                step_d = STEP_STRM;
                rep_d  = {28'd0, strm_ctl.reps};
              end else begin
                step_d = STEP_SEEK;
                rep_d  = blen_q - MIN_BLOCK_LEN - 32'd1;
              end
            end
            FIN_EMIT: step_d = STEP_DONE;
            default: ;
          endcase
        end else begin
          rep_d = rep_q - 32'd1;
        end
      end

      if (in_i.end_of_file) begin
        step_d = STEP_FIRST;
        rep_d  = {28'd0, first_ctl.reps};
        bad_d  = 1'b0;
        mag_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_FIRST;
      rep_q  <= {28'd0, first_ctl.reps};
      bad_q  <= 1'b0;
      mag_q  <= '0;
    end else begin
      step_q <= step_d;
      rep_q  <= rep_d;
      bad_q  <= bad_d;
      mag_q  <= mag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blen_q   <= blen_d;
    usec_q   <= usec_d;
    frames_q <= frames_d;
    width_q  <= width_d;
    height_q <= height_d;
    codec_q  <= codec_d;
  end

  assign seq_o = '{emit:   emit,
                   status: status,
                   usec:   usec_q,
                   frames: frames_q,
                   width:  width_q,
                   height: height_q,
                   codec:  codec_q};

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_DONE) else $error("step counter beyond program");

  a_magic_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_q <= MagicW'(MagicLen)) else $error("magic pointer beyond table");

  a_seek_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_SEEK) |-> (blen_q > MIN_BLOCK_LEN)) else $error("seek with short block");

endmodule

`default_nettype wire
